### src/ppp_pkg.sv
`default_nettype none
package ppp_pkg;

   localparam int WORD_W  = 32;
   localparam int CSR_W   = 64;
   localparam int NUM_REGS = 6;
   localparam int IDX_W   = 3;

   // Row sums stay below 2^(64 - FRAC_BITS) in magnitude; 57 bits hold them
   // for every fraction width down to 8.
   localparam int SUM_W   = 57;

   // Dividend magnitude (h << FRAC_BITS) fits below 2^76.
   localparam int NUM_W   = 76;

   // Quotients wider than this are clipped anyway.
   localparam int QUO_W   = 34;

   localparam logic [IDX_W-1:0] REG_ROW0_A = 3'd0;
   localparam logic [IDX_W-1:0] REG_ROW0_B = 3'd1;
   localparam logic [IDX_W-1:0] REG_ROW1_A = 3'd2;
   localparam logic [IDX_W-1:0] REG_ROW1_B = 3'd3;
   localparam logic [IDX_W-1:0] REG_ROW2_A = 3'd4;
   localparam logic [IDX_W-1:0] REG_ROW2_B = 3'd5;

   // Work carried down the divider chain, one beat per cell.
   typedef struct packed {
      logic                  valid;
      logic [NUM_W-1:0]      num_u;
      logic [NUM_W-1:0]      num_v;
      logic [SUM_W-1:0]      den;
      logic [SUM_W:0]        rem_u;
      logic [SUM_W:0]        rem_v;
      logic [QUO_W-1:0]      quo_u;
      logic [QUO_W-1:0]      quo_v;
      logic                  big_u;
      logic                  big_v;
      logic                  neg_u;
      logic                  neg_v;
      logic                  zero;
   } div_beat_type;

endpackage
`default_nettype wire

### src/ppp_row.sv
`default_nettype none
// One matrix row: three products registered, then floor-shifted and summed.
module ppp_row #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic                              clock,
   input  wire logic                              advance,
   input  wire logic signed [ppp_pkg::WORD_W-1:0] coef0,
   input  wire logic signed [ppp_pkg::WORD_W-1:0] coef1,
   input  wire logic signed [ppp_pkg::WORD_W-1:0] coef2,
   input  wire logic signed [ppp_pkg::WORD_W-1:0] coef3,
   input  wire logic signed [ppp_pkg::WORD_W-1:0] pt_x,
   input  wire logic signed [ppp_pkg::WORD_W-1:0] pt_y,
   input  wire logic signed [ppp_pkg::WORD_W-1:0] pt_z,
   output logic signed [ppp_pkg::SUM_W-1:0]       sum
);
   import ppp_pkg::*;

   localparam int PROD_W = 2 * WORD_W;

   logic signed [PROD_W-1:0] p0_ff, p1_ff, p2_ff;
   logic signed [WORD_W-1:0] c3_ff;
   logic signed [PROD_W-1:0] s0, s1, s2;

   always_ff @(posedge clock) begin
      if (advance) begin
         p0_ff <= coef0 * pt_x;
         p1_ff <= coef1 * pt_y;
         p2_ff <= coef2 * pt_z;
         c3_ff <= coef3;
      end
   end

   // Arithmetic shift rounds toward minus infinity.
   assign s0 = p0_ff >>> FRAC_BITS;
   assign s1 = p1_ff >>> FRAC_BITS;
   assign s2 = p2_ff >>> FRAC_BITS;

   assign sum = SUM_W'(s0) + SUM_W'(s1) + SUM_W'(s2) + SUM_W'(c3_ff);

endmodule
`default_nettype wire

### src/ppp_div_cell.sv
`default_nettype none
// One restoring-division step for both coordinates; the chain of these
// cells produces one quotient bit per cell.
module ppp_div_cell (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   advance,
   input  wire ppp_pkg::div_beat_type  beat_in,
   output ppp_pkg::div_beat_type       beat_out
);
   import ppp_pkg::*;

   div_beat_type beat_ff, beat_in_c;
   logic [SUM_W:0] ru, rv;

   always_comb begin
      beat_in_c = beat_in;
      ru = {beat_in.rem_u[SUM_W-1:0], beat_in.num_u[NUM_W-1]};
      rv = {beat_in.rem_v[SUM_W-1:0], beat_in.num_v[NUM_W-1]};
      beat_in_c.num_u = {beat_in.num_u[NUM_W-2:0], 1'b0};
      beat_in_c.num_v = {beat_in.num_v[NUM_W-2:0], 1'b0};
      beat_in_c.big_u = beat_in.big_u | beat_in.quo_u[QUO_W-1];
      beat_in_c.big_v = beat_in.big_v | beat_in.quo_v[QUO_W-1];
      beat_in_c.quo_u = {beat_in.quo_u[QUO_W-2:0], 1'b0};
      beat_in_c.quo_v = {beat_in.quo_v[QUO_W-2:0], 1'b0};
      if (ru >= {1'b0, beat_in.den}) begin
         ru = ru - {1'b0, beat_in.den};
         beat_in_c.quo_u[0] = 1'b1;
      end
      if (rv >= {1'b0, beat_in.den}) begin
         rv = rv - {1'b0, beat_in.den};
         beat_in_c.quo_v[0] = 1'b1;
      end
      beat_in_c.rem_u = ru;
      beat_in_c.rem_v = rv;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beat_ff.valid <= 1'b0;
      end else if (advance) begin
         beat_ff <= beat_in_c;
      end
   end

   assign beat_out = beat_ff;

endmodule
`default_nettype wire

### src/pinhole_point_projection.sv
`default_nettype none
// Pinhole point projection through a programmed 3x4 camera matrix.
// Software writes the twelve fixed-point coefficients over the csr_ port,
// two per 64-bit register (low word is the lower-numbered column), while
// the block is idle. Each beat on the req_ channel carries one world point;
// each beat on the rsp_ channel returns pixel_u = h0/h2, pixel_v = h1/h2,
// a zero_depth flag when h2 is zero and a saturated flag when a coordinate
// was clipped to 32 bits.
// The pipeline takes one point per cycle while no result waits under rsp_stall.
// Its stages: one multiply stage, loaded at the accepting edge, one row-sum
// stage, one magnitude stage, then one divider cell per dividend bit, and the
// output register. The whole pipeline advances as a unit: while rsp_stall
// holds a waiting result, every stage freezes and req_stall is raised, even
// when some stages are empty. Reset clears the coefficients and every valid
// bit; no results are pending afterwards.
module pinhole_point_projection #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_write,
   input  wire logic [ppp_pkg::IDX_W-1:0]          csr_index,
   input  wire logic [ppp_pkg::CSR_W-1:0]          csr_data,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic signed [ppp_pkg::WORD_W-1:0]  req_world_x,
   input  wire logic signed [ppp_pkg::WORD_W-1:0]  req_world_y,
   input  wire logic signed [ppp_pkg::WORD_W-1:0]  req_world_z,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic signed [ppp_pkg::WORD_W-1:0]       rsp_pixel_u,
   output logic signed [ppp_pkg::WORD_W-1:0]       rsp_pixel_v,
   output logic                                    rsp_zero_depth,
   output logic                                    rsp_saturated
);
   import ppp_pkg::*;

   logic [CSR_W-1:0] coef_ff [NUM_REGS];
   logic advance;
   logic v1_ff, v2_ff;
   logic signed [SUM_W-1:0] h0, h1, h2;
   logic signed [SUM_W-1:0] h0_ff, h1_ff, h2_ff;
   div_beat_type chain [NUM_W+1];
   div_beat_type head;
   logic [SUM_W-1:0] m0, m1, m2;
   logic out_valid_ff;
   logic signed [WORD_W-1:0] u_in, v_in;
   logic sat_in;
   logic [QUO_W-1:0] qu, qv;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_REGS; i++) coef_ff[i] <= '0;
      end else if (csr_write && csr_index < IDX_W'(NUM_REGS)) begin
         coef_ff[csr_index] <= csr_data;
      end
   end

   // The pipeline moves whenever the output slot is free or being taken.
   assign advance   = !out_valid_ff || !rsp_stall;
   assign req_stall = !advance;

   ppp_row #(.FRAC_BITS(FRAC_BITS)) u_row0 (
      .clock, .advance,
      .coef0(coef_ff[REG_ROW0_A][31:0]), .coef1(coef_ff[REG_ROW0_A][63:32]),
      .coef2(coef_ff[REG_ROW0_B][31:0]), .coef3(coef_ff[REG_ROW0_B][63:32]),
      .pt_x(req_world_x), .pt_y(req_world_y), .pt_z(req_world_z), .sum(h0));
   ppp_row #(.FRAC_BITS(FRAC_BITS)) u_row1 (
      .clock, .advance,
      .coef0(coef_ff[REG_ROW1_A][31:0]), .coef1(coef_ff[REG_ROW1_A][63:32]),
      .coef2(coef_ff[REG_ROW1_B][31:0]), .coef3(coef_ff[REG_ROW1_B][63:32]),
      .pt_x(req_world_x), .pt_y(req_world_y), .pt_z(req_world_z), .sum(h1));
   ppp_row #(.FRAC_BITS(FRAC_BITS)) u_row2 (
      .clock, .advance,
      .coef0(coef_ff[REG_ROW2_A][31:0]), .coef1(coef_ff[REG_ROW2_A][63:32]),
      .coef2(coef_ff[REG_ROW2_B][31:0]), .coef3(coef_ff[REG_ROW2_B][63:32]),
      .pt_x(req_world_x), .pt_y(req_world_y), .pt_z(req_world_z), .sum(h2));

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= req_valid;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         h0_ff <= h0;
         h1_ff <= h1;
         h2_ff <= h2;
      end
   end

   assign m0 = h0_ff[SUM_W-1] ? SUM_W'(-h0_ff) : h0_ff;
   assign m1 = h1_ff[SUM_W-1] ? SUM_W'(-h1_ff) : h1_ff;
   assign m2 = h2_ff[SUM_W-1] ? SUM_W'(-h2_ff) : h2_ff;

   always_comb begin
      head       = '0;
      head.valid = v2_ff;
      head.num_u = NUM_W'(m0) << FRAC_BITS;
      head.num_v = NUM_W'(m1) << FRAC_BITS;
      // A zero denominator is replaced by one so the chain stays well behaved.
      head.zero  = (h2_ff == '0);
      head.den   = head.zero ? SUM_W'(1) : m2;
      head.neg_u = h0_ff[SUM_W-1] ^ h2_ff[SUM_W-1];
      head.neg_v = h1_ff[SUM_W-1] ^ h2_ff[SUM_W-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chain[0].valid <= 1'b0;
      end else if (advance) begin
         chain[0] <= head;
      end
   end

   for (genvar g = 0; g < NUM_W; g++) begin : g_cell
      ppp_div_cell u_cell (
         .clock, .reset, .advance,
         .beat_in(chain[g]), .beat_out(chain[g+1]));
   end

   // Quotients of 2^31 or more clip; the negative side allows exactly 2^31.
   function automatic logic signed [WORD_W-1:0] clip_q(
      input logic [QUO_W-1:0] q, input logic big, input logic neg,
      output logic clipped);
      logic over;
      begin
         over = big || (q[QUO_W-1:WORD_W] != '0);
         if (neg) begin
            clipped = over || (q[WORD_W-1:0] > 32'h8000_0000);
            clip_q  = clipped ? 32'sh8000_0000 : WORD_W'(-q[WORD_W-1:0]);
         end else begin
            clipped = over || q[WORD_W-1];
            clip_q  = clipped ? 32'sh7fff_ffff : q[WORD_W-1:0];
         end
      end
   endfunction

   always_comb begin
      logic cu, cv;
      qu = chain[NUM_W].quo_u;
      qv = chain[NUM_W].quo_v;
      u_in = clip_q(qu, chain[NUM_W].big_u, chain[NUM_W].neg_u, cu);
      v_in = clip_q(qv, chain[NUM_W].big_v, chain[NUM_W].neg_v, cv);
      sat_in = (cu || cv) && !chain[NUM_W].zero;
      if (chain[NUM_W].zero) begin
         u_in = '0;
         v_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= chain[NUM_W].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_pixel_u    <= u_in;
         rsp_pixel_v    <= v_in;
         rsp_zero_depth <= chain[NUM_W].zero;
         rsp_saturated  <= sat_in;
      end
   end

   assign rsp_valid = out_valid_ff;

endmodule
`default_nettype wire

### test/tb.sv
`timescale 1ns / 1ps

module tb;
   import ppp_pkg::*;

   localparam int FRAC = 16;
   localparam int LATENCY = NUM_W + 3;

   typedef struct packed {
      logic signed [WORD_W-1:0] x;
      logic signed [WORD_W-1:0] y;
      logic signed [WORD_W-1:0] z;
   } point_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] u;
      logic signed [WORD_W-1:0] v;
      logic                     zero_depth;
      logic                     saturated;
   } pixel_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write = 1'b0;
   logic [IDX_W-1:0] csr_index = '0;
   logic [CSR_W-1:0] csr_data = '0;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [WORD_W-1:0] req_world_x = '0;
   logic signed [WORD_W-1:0] req_world_y = '0;
   logic signed [WORD_W-1:0] req_world_z = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [WORD_W-1:0] rsp_pixel_u;
   logic signed [WORD_W-1:0] rsp_pixel_v;
   logic rsp_zero_depth;
   logic rsp_saturated;

   logic [CSR_W-1:0] matrix_regs [NUM_REGS];
   point_type pending_points [$];
   pixel_type expected_pixels [$];
   int error_count = 0;
   int hold_off_cycles = 0;
   int burst_left = 0;
   int gap_left = 0;
   int stall_mode = 0;

   pinhole_point_projection #(.FRAC_BITS(FRAC)) i_dut (
      .clock(clock), .reset(reset),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_world_x(req_world_x), .req_world_y(req_world_y),
      .req_world_z(req_world_z),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_pixel_u(rsp_pixel_u), .rsp_pixel_v(rsp_pixel_v),
      .rsp_zero_depth(rsp_zero_depth), .rsp_saturated(rsp_saturated)
   );

   always #5 clock = ~clock;

   task automatic add_point(point_type p);
      pending_points.insert(pending_points.size(), p);
   endtask

   task automatic add_expected(pixel_type r);
      expected_pixels.insert(expected_pixels.size(), r);
   endtask

   function automatic logic signed [63:0] coef(int row, int col);
      logic [CSR_W-1:0] reg_word;
      reg_word = matrix_regs[row * 2 + col / 2];
      return (col % 2) ? 64'(signed'(reg_word[63:32])) : 64'(signed'(reg_word[31:0]));
   endfunction

   function automatic logic signed [63:0] row_sum(int row, point_type p);
      logic signed [63:0] acc;
      logic signed [63:0] prod;
      acc = coef(row, 3);
      prod = coef(row, 0) * 64'(p.x);
      acc += prod >>> FRAC;
      prod = coef(row, 1) * 64'(p.y);
      acc += prod >>> FRAC;
      prod = coef(row, 2) * 64'(p.z);
      acc += prod >>> FRAC;
      return acc;
   endfunction

   // Truncated (num << FRAC) / den, clipped to 32 bits.
   function automatic logic signed [WORD_W-1:0] fixed_quotient(
         logic signed [63:0] num, logic signed [63:0] den, inout logic clip);
      logic [127:0] n_mag;
      logic [127:0] d_mag;
      logic [127:0] q;
      logic neg;
      n_mag = num < 0 ? 128'(-num) : 128'(num);
      d_mag = den < 0 ? 128'(-den) : 128'(den);
      n_mag = n_mag << FRAC;
      q = n_mag / d_mag;
      neg = (num < 0) != (den < 0);
      if (neg) begin
         if (q > 128'h8000_0000) begin
            clip = 1'b1;
            return 32'h8000_0000;
         end
         return WORD_W'(-q);
      end
      if (q > 128'h7FFF_FFFF) begin
         clip = 1'b1;
         return 32'h7FFF_FFFF;
      end
      return WORD_W'(q);
   endfunction

   function automatic pixel_type project_point(point_type p);
      pixel_type r;
      logic signed [63:0] h0, h1, h2;
      logic clip;
      clip = 1'b0;
      r = '0;
      h0 = row_sum(0, p);
      h1 = row_sum(1, p);
      h2 = row_sum(2, p);
      if (h2 == 0) begin
         r.zero_depth = 1'b1;
      end else begin
         r.u = fixed_quotient(h0, h2, clip);
         r.v = fixed_quotient(h1, h2, clip);
         r.saturated = clip;
      end
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("error at %0t: %s got %h, want %h", $time, what, got, want);
      error_count++;
   endtask

   // Driver: bursts of beats separated by random gaps.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (req_valid) begin
            add_expected(project_point(
               '{x: req_world_x, y: req_world_y, z: req_world_z}));
         end
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pending_points.size() > 0) begin
            point_type p;
            p = pending_points.pop_front();
            req_valid <= 1'b1;
            req_world_x <= p.x;
            req_world_y <= p.y;
            req_world_z <= p.z;
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(40, 1);
               gap_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(6);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver stall pattern, with an occasional long hold-off.
   always @(posedge clock) begin
      if (hold_off_cycles > 0) begin
         hold_off_cycles--;
         rsp_stall <= 1'b1;
      end else begin
         if ($urandom_range(199) == 0) stall_mode = $urandom_range(2);
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(3) == 0);
            default: rsp_stall <= ($urandom_range(1) == 0);
         endcase
      end
   end

   // Monitor.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_pixels.size() == 0) begin
            report_mismatch("unexpected beat", rsp_pixel_u, 0);
         end else begin
            pixel_type want;
            want = expected_pixels.pop_front();
            if (rsp_pixel_u !== want.u) report_mismatch("pixel_u", rsp_pixel_u, want.u);
            if (rsp_pixel_v !== want.v) report_mismatch("pixel_v", rsp_pixel_v, want.v);
            if (rsp_zero_depth !== want.zero_depth)
               report_mismatch("zero_depth", rsp_zero_depth, want.zero_depth);
            if (rsp_saturated !== want.saturated)
               report_mismatch("saturated", rsp_saturated, want.saturated);
         end
      end
   end

   // Leaves csr_write high; the caller lowers it after the last register.
   task automatic write_reg(logic [IDX_W-1:0] index, logic [CSR_W-1:0] value);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      matrix_regs[index] = value;
      @(posedge clock);
   endtask

   function automatic logic [WORD_W-1:0] random_word();
      case ($urandom_range(5))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'($urandom_range(8 << FRAC)) - 32'(4 << FRAC);
         3: return 32'($urandom_range(255));
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [WORD_W-1:0] q16(int whole);
      return 32'(whole) << FRAC;
   endfunction

   // Sampled at the falling edge so the driver's updates have settled.
   task automatic wait_drained();
      while (pending_points.size() > 0 || req_valid || expected_pixels.size() > 0)
         @(negedge clock);
      repeat (LATENCY + 5) @(posedge clock);
   endtask

   task automatic load_matrix(int setting);
      logic [WORD_W-1:0] c [12];
      for (int i = 0; i < 12; i++) begin
         case (setting)
            0: c[i] = 32'h7FFF_FFFF;
            1: c[i] = 32'h8000_0000;
            2: c[i] = (i == 11 || i == 0 || i == 5) ? q16(1) : '0;
            3: c[i] = random_word();
            default: c[i] = (i == 10) ? q16(1) : 32'($urandom_range(4 << FRAC));
         endcase
      end
      // A realistic camera: focal length, principal point, depth from z.
      if (setting == 4) begin
         c[0] = q16(500); c[2] = q16(320); c[5] = q16(500); c[6] = q16(240);
         c[8] = '0; c[9] = '0; c[11] = $urandom_range(1) ? q16(2) : '0;
      end
      write_reg(REG_ROW0_A, {c[1], c[0]});
      write_reg(REG_ROW0_B, {c[3], c[2]});
      write_reg(REG_ROW1_A, {c[5], c[4]});
      write_reg(REG_ROW1_B, {c[7], c[6]});
      write_reg(REG_ROW2_A, {c[9], c[8]});
      write_reg(REG_ROW2_B, {c[11], c[10]});
      csr_write <= 1'b0;
   endtask

   function automatic point_type random_point();
      return '{x: random_word(), y: random_word(), z: random_word()};
   endfunction

   initial begin
      for (int i = 0; i < NUM_REGS; i++) matrix_regs[i] = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Zero matrix: every point has zero depth.
      add_point('{x: 32'h7FFF_FFFF, y: 32'h8000_0000, z: 0});
      wait_drained();

      load_matrix(2);
      add_point('{x: 0, y: 0, z: 0});
      add_point('{x: 32'h7FFF_FFFF, y: 32'h7FFF_FFFF, z: 32'h7FFF_FFFF});
      add_point('{x: 32'h8000_0000, y: 32'h8000_0000, z: 32'h8000_0000});
      add_point('{x: 32'hFFFF_FFFF, y: 32'h0000_0001, z: q16(-1)});
      add_point('{x: q16(3), y: q16(-7), z: q16(2)});
      wait_drained();

      for (int s = 0; s < 2; s++) begin
         load_matrix(s);
         add_point('{x: 32'h7FFF_FFFF, y: 32'h8000_0000, z: 1});
         add_point('{x: 0, y: 0, z: 0});
         add_point('{x: 32'h8000_0000, y: 32'h8000_0000, z: 32'h8000_0000});
         add_point('{x: 32'h7FFF_FFFF, y: 32'h7FFF_FFFF, z: 32'h7FFF_FFFF});
         for (int i = 0; i < 6; i++) add_point(random_point());
         wait_drained();
      end

      for (int phase = 0; phase < 9; phase++) begin
         load_matrix(phase % 3 + 2);
         for (int i = 0; i < 100; i++) begin
            point_type p;
            p = random_point();
            // Some points sit at the origin, where the depth is the row-2 offset coefficient alone.
            if ($urandom_range(9) == 0) begin
               p.x = '0; p.y = '0; p.z = '0;
            end
            add_point(p);
         end
         if (phase == 4) hold_off_cycles = 3 * LATENCY;
         wait_drained();
      end

      if (error_count == 0) begin
         $display("pinhole_point_projection: match");
      end else begin
         $display("pinhole_point_projection: mismatch");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("pinhole_point_projection: mismatch");
      $finish;
   end

endmodule
